/* src/ibls_pkg.sv */
// ----------------------------------------------------------------------------
// ibls_pkg
// Shared types, codes and defaults for the indexed byte list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ibls_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 64;
   localparam int unsigned POS_W            = 7;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned KIND_W           = 3;
   localparam int unsigned STATUS_W         = 2;
   localparam int unsigned COUNT_OUT_W      = 7;

   typedef enum logic [KIND_W-1:0] {
      REQ_INSERT = 3'd0,
      REQ_REMOVE = 3'd1,
      REQ_READ   = 3'd2,
      REQ_WRITE  = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic              wr;
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] val;
   } ctrl_type;

endpackage

`default_nettype wire

/* src/ibls_cell.sv */
// ----------------------------------------------------------------------------
// ibls_cell
// One byte slot of the list; shifts toward or away from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module ibls_cell #(
   parameter int unsigned IDX_W = 7,
   parameter int unsigned INDEX = 0
) (
   input  wire logic                          clock,
   input  wire ibls_pkg::ctrl_type            ctrl,
   input  wire logic [ibls_pkg::BYTE_W-1:0]   prev_data,
   input  wire logic [ibls_pkg::BYTE_W-1:0]   next_data,
   output logic      [ibls_pkg::BYTE_W-1:0]   data,
   output logic      [ibls_pkg::BYTE_W-1:0]   read_data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [ibls_pkg::BYTE_W-1:0] data_ff;
   logic [ibls_pkg::BYTE_W-1:0] data_in;
   logic [IDX_W-1:0]            pos_ext;
   logic                        at_pos;
   logic                        above_pos;

   assign pos_ext   = IDX_W'(ctrl.pos);
   assign at_pos    = (MY_IDX == pos_ext);
   assign above_pos = (MY_IDX > pos_ext);

   always_comb begin
      data_in = data_ff;
      priority if (ctrl.ins) begin
         if (above_pos) begin
            data_in = prev_data;
         end else if (at_pos) begin
            data_in = ctrl.val;
         end
      end else if (ctrl.rem) begin
         if (above_pos || at_pos) begin
            data_in = next_data;
         end
      end else if (ctrl.wr) begin
         if (at_pos) begin
            data_in = ctrl.val;
         end
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign read_data = at_pos ? data_ff : '0;

endmodule

`default_nettype wire

/* src/indexed_byte_list_store_unit.sv */
// ----------------------------------------------------------------------------
// indexed_byte_list_store_unit
// Ordered byte list held in a row of shifting cells; indexed insert, remove,
// read, write and clear.
// ----------------------------------------------------------------------------
// Response valid is registered and rises in the cycle after the request is accepted.
// Throughput: 1 request per cycle while the response is taken; the affected cells
// of the row shift in the same cycle, and the response register frees as soon as it is taken.
// Reset: count and handshake state cleared; cell contents are not reset.
`default_nettype none

module indexed_byte_list_store_unit #(
   parameter int unsigned CAPACITY = ibls_pkg::CAPACITY_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // position[6:0], byte_value[14:7], pad
   input  wire logic [2:0]  req_tuser,   // req_type[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // read_byte[7:0], entry_count[14:8], pad
   output logic      [1:0]  rsp_tuser    // status[1:0]
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > ibls_pkg::POS_W) ? CNT_W : ibls_pkg::POS_W;
   localparam int unsigned IDX_W = ($clog2(CAPACITY) > ibls_pkg::POS_W) ?
                                   $clog2(CAPACITY) : ibls_pkg::POS_W;
   localparam logic [CMP_W-1:0] CAP_VAL = CMP_W'(CAPACITY);

   logic [ibls_pkg::BYTE_W-1:0] cell_data [CAPACITY];
   logic [ibls_pkg::BYTE_W-1:0] cell_read [CAPACITY];
   logic [ibls_pkg::BYTE_W-1:0] read_any;

   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ibls_pkg::status_type         status_ff;
   ibls_pkg::status_type         status_in;
   logic [ibls_pkg::BYTE_W-1:0]  rd_ff;
   logic [ibls_pkg::BYTE_W-1:0]  rd_in;
   logic [ibls_pkg::COUNT_OUT_W-1:0] cnt_out_ff;
   logic [ibls_pkg::COUNT_OUT_W-1:0] cnt_out_in;

   logic                         accept;
   ibls_pkg::ctrl_type           ctrl;
   logic [CMP_W-1:0]             pos_c;
   logic [CMP_W-1:0]             cnt_c;
   logic [CMP_W-1:0]             cnt_new_c;
   logic [ibls_pkg::KIND_W-1:0]  kind;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign kind       = req_tuser;
   assign pos_c      = CMP_W'(req_tdata[6:0]);
   assign cnt_c      = CMP_W'(count_ff);

   always_comb begin
      read_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_any = read_any | cell_read[i];
      end
   end

   always_comb begin
      ctrl.ins  = 1'b0;
      ctrl.rem  = 1'b0;
      ctrl.wr   = 1'b0;
      ctrl.pos  = req_tdata[6:0];
      ctrl.val  = req_tdata[14:7];
      status_in = ibls_pkg::STATUS_OK;
      rd_in     = '0;
      count_in  = count_ff;
      unique case (kind)
         ibls_pkg::REQ_INSERT: begin
            if (pos_c > cnt_c) begin
               status_in = ibls_pkg::STATUS_RANGE;
            end else if (cnt_c == CAP_VAL) begin
               status_in = ibls_pkg::STATUS_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ibls_pkg::REQ_REMOVE: begin
            if (pos_c >= cnt_c) begin
               status_in = ibls_pkg::STATUS_RANGE;
            end else begin
               ctrl.rem = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ibls_pkg::REQ_READ: begin
            if (pos_c >= cnt_c) begin
               status_in = ibls_pkg::STATUS_RANGE;
            end else begin
               rd_in = read_any;
            end
         end
         ibls_pkg::REQ_WRITE: begin
            if (pos_c >= cnt_c) begin
               status_in = ibls_pkg::STATUS_RANGE;
            end else begin
               ctrl.wr = accept;
            end
         end
         ibls_pkg::REQ_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_in = ibls_pkg::STATUS_RANGE;
         end
      endcase
   end

   assign cnt_new_c    = CMP_W'(count_in);
   assign cnt_out_in   = cnt_new_c[ibls_pkg::COUNT_OUT_W-1:0];
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ibls_pkg::BYTE_W-1:0] prev_d;
      logic [ibls_pkg::BYTE_W-1:0] next_d;
      if (g == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_prev
         assign prev_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_mid_next
         assign next_d = cell_data[g+1];
      end
      ibls_cell #(
         .IDX_W (IDX_W),
         .INDEX (g)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .prev_data (prev_d),
         .next_data (next_d),
         .data      (cell_data[g]),
         .read_data (cell_read[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         rd_ff      <= rd_in;
         cnt_out_ff <= cnt_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, cnt_out_ff, rd_ff};
   assign rsp_tuser  = status_ff;

endmodule

`default_nettype wire
